>>> design/lcdseq_pkg.sv
// Shared types, codes and constants of the character LCD nibble write sequencer.
package lcdseq_pkg;

   // Default width of the phase timer.
   localparam int TIMER_WIDTH_DEFAULT = 16;

   // Width of each timing register on the configuration port.
   localparam int CSR_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 2;

   // Reset values of the timing registers.
   localparam logic [CSR_WIDTH-1:0] PULSE_RESET = 16'd10;
   localparam logic [CSR_WIDTH-1:0] GAP_RESET = 16'd1;
   localparam logic [CSR_WIDTH-1:0] SETTLE_RESET = 16'd3;
   localparam logic [CSR_WIDTH-1:0] POWER_ON_RESET = 16'd15;

   // Init command sequence, sent with RS low.
   localparam logic [7:0] INIT_CMD_0 = 8'h02;
   localparam logic [7:0] INIT_CMD_1 = 8'h28;
   localparam logic [7:0] INIT_CMD_2 = 8'h01;
   localparam logic [7:0] INIT_CMD_3 = 8'h0C;
   localparam logic [7:0] INIT_CMD_4 = 8'h06;
   localparam logic [2:0] INIT_LAST_STEP = 3'd4;

   // Request operation codes.
   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_SUBMIT = 2'd1,
      OP_INIT   = 2'd2
   } op_type;

   // Timing register indexes.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_PULSE    = 2'd0,
      REG_GAP      = 2'd1,
      REG_SETTLE   = 2'd2,
      REG_POWER_ON = 2'd3
   } csr_reg_type;

   // Sequencer phases, one-hot.
   typedef enum logic [5:0] {
      PH_IDLE   = 6'b000001,
      PH_POWER  = 6'b000010,
      PH_HIGH   = 6'b000100,
      PH_GAP    = 6'b001000,
      PH_LOW    = 6'b010000,
      PH_SETTLE = 6'b100000
   } phase_type;

   // Timing registers and their nonzero flags after cutting to the timer width.
   typedef struct packed {
      logic [CSR_WIDTH-1:0] pulse;
      logic [CSR_WIDTH-1:0] gap;
      logic [CSR_WIDTH-1:0] settle;
      logic [CSR_WIDTH-1:0] power_on;
      logic                 pulse_nz;
      logic                 gap_nz;
      logic                 settle_nz;
      logic                 power_on_nz;
   } timing_type;

   // One request as it enters the sequencer.
   typedef struct packed {
      logic [1:0] op;
      logic [7:0] data_byte;
      logic       rs_select;
   } item_type;

   // LCD pin levels.
   typedef struct packed {
      logic [3:0] nibble;
      logic       rs;
      logic       e;
   } pins_type;

   // One result as it leaves the sequencer.
   typedef struct packed {
      logic       accepted;
      logic       busy;
      logic [3:0] data_nibble;
      logic       rs_level;
      logic       e_level;
   } result_type;

   // Init command for a given step; steps past the end fall back to the first.
   function automatic logic [7:0] init_cmd(input logic [2:0] step);
      logic [7:0] cmd;
      case (step)
         3'd0:    cmd = INIT_CMD_0;
         3'd1:    cmd = INIT_CMD_1;
         3'd2:    cmd = INIT_CMD_2;
         3'd3:    cmd = INIT_CMD_3;
         3'd4:    cmd = INIT_CMD_4;
         default: cmd = INIT_CMD_0;
      endcase
      return cmd;
   endfunction

endpackage

>>> design/lcdseq_csr.sv
// Timing register file of the LCD sequencer with zero-time flags.
module lcdseq_csr import lcdseq_pkg::*; #(
   parameter int TIMER_WIDTH = TIMER_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0]       csr_wdata,
   output timing_type                 timing
);

   logic [CSR_WIDTH-1:0] pulse_ff;
   logic [CSR_WIDTH-1:0] gap_ff;
   logic [CSR_WIDTH-1:0] settle_ff;
   logic [CSR_WIDTH-1:0] power_on_ff;

   // Register writes, decoded by index.
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ff    <= PULSE_RESET;
         gap_ff      <= GAP_RESET;
         settle_ff   <= SETTLE_RESET;
         power_on_ff <= POWER_ON_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_PULSE:    pulse_ff <= csr_wdata;
            REG_GAP:      gap_ff <= csr_wdata;
            REG_SETTLE:   settle_ff <= csr_wdata;
            REG_POWER_ON: power_on_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A time that is zero once cut to the timer width is skipped by the sequencer.
   always_comb begin
      timing.pulse       = pulse_ff;
      timing.gap         = gap_ff;
      timing.settle      = settle_ff;
      timing.power_on    = power_on_ff;
      timing.pulse_nz    = |TIMER_WIDTH'(pulse_ff);
      timing.gap_nz      = |TIMER_WIDTH'(gap_ff);
      timing.settle_nz   = |TIMER_WIDTH'(settle_ff);
      timing.power_on_nz = |TIMER_WIDTH'(power_on_ff);
   end

endmodule

>>> design/lcdseq_engine.sv
// Phase sequencer of the LCD interface: state registers and one-pass next-state logic.
module lcdseq_engine import lcdseq_pkg::*; #(
   parameter int TIMER_WIDTH = TIMER_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       item_go,
   input  item_type   item,
   input  timing_type timing,
   output result_type result
);

   phase_type              phase_ff, phase_in;
   logic [TIMER_WIDTH-1:0] timer_ff, timer_in;
   logic [7:0]             byte_ff, byte_in;
   logic                   rs_ff, rs_in;
   logic [2:0]             step_ff, step_in;
   logic                   init_ff, init_in;
   pins_type               pins_ff, pins_in;
   logic                   accepted;

   // Entry point of a run through the nibble phases.
   logic       walk;
   logic [2:0] walk_pos;
   logic [2:0] walk_step;
   logic [7:0] walk_byte;
   logic       walk_rs;
   logic       walk_init;

   // Where the run stops.
   logic [3:0] nz;
   logic       cur_hit, next_hit, can_next;
   logic [1:0] cur_pos, next_pos, stop_pos;
   logic [2:0] stop_step;
   logic [7:0] stop_byte;
   logic       stop_rs;

   // Nonzero flags by position within a byte: high, gap, low, settle.
   assign nz = {timing.settle_nz, timing.pulse_nz, timing.gap_nz, timing.pulse_nz};

   // Decode the request and find where the run through zero-time phases starts.
   always_comb begin
      phase_in  = phase_ff;
      timer_in  = timer_ff;
      byte_in   = byte_ff;
      rs_in     = rs_ff;
      step_in   = step_ff;
      init_in   = init_ff;
      pins_in   = pins_ff;
      accepted  = 1'b0;
      walk      = 1'b0;
      walk_pos  = 3'd0;
      walk_step = step_ff;
      walk_byte = byte_ff;
      walk_rs   = rs_ff;
      walk_init = init_ff;
      if (item_go) begin
         case (item.op)
            OP_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  if (timer_ff > TIMER_WIDTH'(1)) begin
                     timer_in = timer_ff - TIMER_WIDTH'(1);
                  end else begin
                     walk = 1'b1;
                     case (phase_ff)
                        PH_POWER: begin
                           walk_pos  = 3'd0;
                           walk_step = 3'd0;
                           walk_byte = init_cmd(3'd0);
                           walk_rs   = 1'b0;
                        end
                        PH_HIGH:   walk_pos = 3'd1;
                        PH_GAP:    walk_pos = 3'd2;
                        PH_LOW:    walk_pos = 3'd3;
                        PH_SETTLE: walk_pos = 3'd4;
                        default:   walk_pos = 3'd4;
                     endcase
                  end
               end
            end
            OP_SUBMIT: begin
               if (phase_ff == PH_IDLE) begin
                  accepted  = 1'b1;
                  walk      = 1'b1;
                  walk_pos  = 3'd0;
                  walk_step = 3'd0;
                  walk_byte = item.data_byte;
                  walk_rs   = item.rs_select;
                  walk_init = 1'b0;
               end
            end
            OP_INIT: begin
               if (phase_ff == PH_IDLE) begin
                  accepted  = 1'b1;
                  walk_init = 1'b1;
                  walk_step = 3'd0;
                  init_in   = 1'b1;
                  step_in   = 3'd0;
                  if (timing.power_on_nz) begin
                     phase_in = PH_POWER;
                     timer_in = TIMER_WIDTH'(timing.power_on);
                  end else begin
                     walk      = 1'b1;
                     walk_pos  = 3'd0;
                     walk_byte = init_cmd(3'd0);
                     walk_rs   = 1'b0;
                  end
               end
            end
            default: ;
         endcase
      end

      // First nonzero phase from the entry point on, in this byte or the next.
      cur_hit  = 1'b0;
      cur_pos  = 2'd0;
      next_hit = 1'b0;
      next_pos = 2'd0;
      for (int i = 0; i < 4; i++) begin
         if (!cur_hit && (3'(i) >= walk_pos) && nz[i]) begin
            cur_hit = 1'b1;
            cur_pos = 2'(i);
         end
         if (!next_hit && nz[i]) begin
            next_hit = 1'b1;
            next_pos = 2'(i);
         end
      end
      can_next = walk_init && (walk_step < INIT_LAST_STEP);

      stop_pos  = cur_hit ? cur_pos : next_pos;
      stop_step = cur_hit ? walk_step : walk_step + 3'd1;
      stop_byte = cur_hit ? walk_byte : init_cmd(walk_step + 3'd1);
      stop_rs   = cur_hit ? walk_rs : 1'b0;

      if (walk) begin
         if (cur_hit || (can_next && next_hit)) begin
            // Stop in a nibble phase and load its time.
            step_in    = stop_step;
            byte_in    = stop_byte;
            rs_in      = stop_rs;
            init_in    = walk_init;
            pins_in.rs = stop_rs;
            pins_in.e  = ~stop_pos[0];
            pins_in.nibble = stop_pos[1] ? stop_byte[3:0] : stop_byte[7:4];
            case (stop_pos)
               2'd0: begin
                  phase_in = PH_HIGH;
                  timer_in = TIMER_WIDTH'(timing.pulse);
               end
               2'd1: begin
                  phase_in = PH_GAP;
                  timer_in = TIMER_WIDTH'(timing.gap);
               end
               2'd2: begin
                  phase_in = PH_LOW;
                  timer_in = TIMER_WIDTH'(timing.pulse);
               end
               default: begin
                  phase_in = PH_SETTLE;
                  timer_in = TIMER_WIDTH'(timing.settle);
               end
            endcase
         end else begin
            // Every remaining phase takes no time: finish with the last byte sent.
            phase_in = PH_IDLE;
            timer_in = '0;
            init_in  = 1'b0;
            step_in  = 3'd0;
            byte_in  = can_next ? INIT_CMD_4 : walk_byte;
            rs_in    = can_next ? 1'b0 : walk_rs;
            pins_in.e      = 1'b0;
            pins_in.rs     = rs_in;
            pins_in.nibble = byte_in[3:0];
         end
      end
   end

   // Sequencer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         timer_ff <= '0;
         step_ff  <= 3'd0;
         init_ff  <= 1'b0;
         pins_ff  <= '0;
         byte_ff  <= '0;
         rs_ff    <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         step_ff  <= step_in;
         init_ff  <= init_in;
         pins_ff  <= pins_in;
         byte_ff  <= byte_in;
         rs_ff    <= rs_in;
      end
   end

   // Result of the request being processed.
   always_comb begin
      result.e_level     = pins_in.e;
      result.rs_level    = pins_in.rs;
      result.data_nibble = pins_in.nibble;
      result.busy        = (phase_in != PH_IDLE);
      result.accepted    = accepted;
   end

   // A running phase always has time left on its timer.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_IDLE |-> timer_ff != '0)
      else $error("phase running with an empty timer");

   // The init sequence never outlives the busy period.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> !init_ff && step_ff == 3'd0)
      else $error("init sequence state left over while idle");

   // E is high only while a nibble is being strobed.
   assert property (@(posedge clock) disable iff (reset)
      pins_ff.e |-> phase_ff == PH_HIGH || phase_ff == PH_LOW)
      else $error("E high outside a strobe phase");

   // The init step never runs past the last command.
   assert property (@(posedge clock) disable iff (reset)
      step_ff <= INIT_LAST_STEP)
      else $error("init step out of range");

endmodule

>>> design/char_lcd_nibble_write_sequencer.sv
// Top level of the character LCD nibble write sequencer: request and result registers.
//
// Drives a character LCD over a 4-bit bus. Each request on the req_ channel is a
// tick (time passes), a byte submit or an init start; each request produces
// exactly one result on the rsp_ channel with the pin levels after it (E, RS,
// D7..D4), a busy flag and whether a submit or init was taken. Submits and init
// starts made while busy are refused. Timing registers are written through the
// csr_ port, counted in ticks; a zero time skips its phase.
// An accepted request is registered in the request register, processed when
// the result register is free or being emptied, and its result is then valid.
// Throughput: one request per cycle while the receiver does not stall; the
// whole phase step, including any chain of zero-time phases, is done in the
// single stage between the request register and the result register.
// Reset clears the sequencer to idle with all pins low and loads the timing
// defaults. When the receiver stalls, the result is held and one more request
// may wait in the request register; then req_tready drops until rsp_tready.
module char_lcd_nibble_write_sequencer import lcdseq_pkg::*; #(
   parameter int TIMER_WIDTH = TIMER_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   // Request channel.
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,  // [7:0] data_byte
   input  logic [2:0]                 req_tuser,  // [1:0] op, [2] rs_select
   // Result channel.
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,  // [0] e_level, [1] rs_level,
                                                  // [5:2] data_nibble, [6] busy_res,
                                                  // [7] accepted
   // Timing register writes.
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0]       csr_wdata
);

   logic       req_valid_ff;
   item_type   req_item_ff;
   logic       rsp_valid_ff;
   result_type rsp_data_ff;
   logic       advance;
   timing_type timing;
   result_type result;

   // A held request moves on when the result register is free or being emptied.
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_item_ff.op        <= req_tuser[1:0];
         req_item_ff.data_byte <= req_tdata;
         req_item_ff.rs_select <= req_tuser[2];
      end
   end

   lcdseq_csr #(
      .TIMER_WIDTH(TIMER_WIDTH)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .timing    (timing)
   );

   lcdseq_engine #(
      .TIMER_WIDTH(TIMER_WIDTH)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .item_go (advance),
      .item    (req_item_ff),
      .timing  (timing),
      .result  (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> tb/sv/char_lcd_nibble_write_sequencer_tb.sv
// Self-checking testbench of the character LCD nibble write sequencer with its pin predictor.
module char_lcd_nibble_write_sequencer_tb import lcdseq_pkg::*;;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int unsigned LONG_HOLD = 200;
   localparam int unsigned ITEMS_PER_PHASE = 110;
   localparam int unsigned RANDOM_PHASES = 8;
   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam int unsigned DRAIN_CYCLES = 4;

   // Tracks the LCD sequencer state and the pin levels expected after each request.
   class lcd_pin_scoreboard;
      logic [CSR_WIDTH-1:0] pulse_len, gap_len, settle_len, power_len;
      phase_type            phase;
      logic [15:0]          timer;
      logic [7:0]           held_byte;
      logic                 held_rs;
      int unsigned          cmd_step;
      bit                   in_init;
      pins_type             pins;
      logic [7:0]           init_seq [5] = '{INIT_CMD_0, INIT_CMD_1, INIT_CMD_2,
                                             INIT_CMD_3, INIT_CMD_4};
      result_type           pin_results_q[$];
      int unsigned          failures;
      int unsigned          checked;

      function new();
         pulse_len = PULSE_RESET;
         gap_len = GAP_RESET;
         settle_len = SETTLE_RESET;
         power_len = POWER_ON_RESET;
         phase = PH_IDLE;
         timer = '0;
         held_byte = '0;
         held_rs = 1'b0;
         cmd_step = 0;
         in_init = 1'b0;
         pins = '0;
         failures = 0;
         checked = 0;
      endfunction

      function void set_reg(csr_reg_type idx, logic [CSR_WIDTH-1:0] value);
         case (idx)
            REG_PULSE:    pulse_len = value;
            REG_GAP:      gap_len = value;
            REG_SETTLE:   settle_len = value;
            REG_POWER_ON: power_len = value;
            default:      ;
         endcase
      endfunction

      function bit busy();
         return phase != PH_IDLE;
      endfunction

      function int pending();
         return pin_results_q.size();
      endfunction

      function void load_cmd();
         held_byte = init_seq[cmd_step];
         held_rs = 1'b0;
      endfunction

      // Phase that comes after ph once its count has run out.
      function phase_type following_phase(phase_type ph);
         case (ph)
            PH_POWER: begin
               cmd_step = 0;
               load_cmd();
               return PH_HIGH;
            end
            PH_HIGH:  return PH_GAP;
            PH_GAP:   return PH_LOW;
            PH_LOW:   return PH_SETTLE;
            PH_SETTLE: begin
               if (in_init) begin
                  cmd_step++;
                  if (cmd_step < 5) begin
                     load_cmd();
                     return PH_HIGH;
                  end
                  in_init = 1'b0;
                  cmd_step = 0;
               end
               return PH_IDLE;
            end
            default:  return PH_IDLE;
         endcase
      endfunction

      // Enters a phase, sets its pins and passes straight through phases of zero time.
      function void enter(phase_type start_ph);
         phase_type   ph;
         logic [15:0] t;
         bit          settled;
         ph = start_ph;
         settled = 1'b0;
         while (!settled) begin
            t = '0;
            case (ph)
               PH_POWER: t = power_len;
               PH_HIGH: begin
                  pins.nibble = held_byte[7:4];
                  pins.rs = held_rs;
                  pins.e = 1'b1;
                  t = pulse_len;
               end
               PH_GAP: begin
                  pins.e = 1'b0;
                  t = gap_len;
               end
               PH_LOW: begin
                  pins.nibble = held_byte[3:0];
                  pins.e = 1'b1;
                  t = pulse_len;
               end
               PH_SETTLE: begin
                  pins.e = 1'b0;
                  t = settle_len;
               end
               default: begin
                  phase = PH_IDLE;
                  timer = '0;
                  settled = 1'b1;
               end
            endcase
            if (!settled) begin
               if (t != '0) begin
                  phase = ph;
                  timer = t;
                  settled = 1'b1;
               end else begin
                  ph = following_phase(ph);
               end
            end
         end
      endfunction

      // Applies one accepted request; returns 1 when it did more than sit idle.
      function bit note_request(logic [1:0] op, logic [7:0] data_byte, logic rs_select);
         result_type expect_pins;
         logic       taken;
         bit         moved;
         taken = 1'b0;
         moved = busy();
         if (op == OP_TICK) begin
            if (busy()) begin
               if (timer != '0) timer--;
               if (timer == '0) enter(following_phase(phase));
            end
         end else if (op == OP_SUBMIT) begin
            if (!busy()) begin
               held_byte = data_byte;
               held_rs = rs_select;
               taken = 1'b1;
               enter(PH_HIGH);
            end
         end else if (op == OP_INIT) begin
            if (!busy()) begin
               in_init = 1'b1;
               cmd_step = 0;
               taken = 1'b1;
               enter(PH_POWER);
            end
         end
         // The unused operation code changes nothing.
         expect_pins.e_level = pins.e;
         expect_pins.rs_level = pins.rs;
         expect_pins.data_nibble = pins.nibble;
         expect_pins.busy = busy();
         expect_pins.accepted = taken;
         pin_results_q.push_back(expect_pins);
         return (op == OP_TICK && moved) || taken;
      endfunction

      // Compares one result with the oldest expected pin state.
      function void check_result(result_type got);
         result_type want;
         bit         bad;
         checked++;
         if (pin_results_q.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("result %0d arrived with no request outstanding: %h", checked, got);
            return;
         end
         want = pin_results_q.pop_front();
         bad = (got.e_level !== want.e_level) || (got.rs_level !== want.rs_level) ||
               (got.data_nibble !== want.data_nibble) || (got.busy !== want.busy) ||
               (got.accepted !== want.accepted);
         if (bad) begin
            failures++;
            if (failures <= 10)
               $display({"result %0d mismatch: expected e=%b rs=%b nibble=%h busy=%b acc=%b,",
                         " got e=%b rs=%b nibble=%h busy=%b acc=%b"}, checked,
                        want.e_level, want.rs_level, want.data_nibble, want.busy,
                        want.accepted, got.e_level, got.rs_level, got.data_nibble,
                        got.busy, got.accepted);
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [7:0]                 req_tdata = '0;
   logic [2:0]                 req_tuser = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [7:0]                 rsp_tdata;
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_WIDTH-1:0]       csr_wdata = '0;

   lcd_pin_scoreboard sb;
   bit                long_hold_req = 1'b0;
   bit                fast_mode = 1'b0;
   bit                steady = 1'b0;
   int unsigned       active_requests = 0;
   int unsigned       cycle_count = 0;
   int unsigned       rsp_hold = 0;
   int unsigned       rsp_run = 0;

   char_lcd_nibble_write_sequencer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Idle lengths: mostly none or short, now and then long.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Phase times: mostly small so that sequences finish, zero often enough to skip phases.
   function automatic logic [15:0] pick_time();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 15) return 16'd0;
      if (r < 80) return 16'($urandom_range(1, 4));
      if (r < 95) return 16'($urandom_range(5, 20));
      return 16'($urandom_range(21, 40));
   endfunction

   // Receiver: random stalls, plus one long hold-off when the sender asks for it.
   always @(negedge clock) begin
      if (long_hold_req) begin
         long_hold_req = 1'b0;
         rsp_hold = LONG_HOLD;
         rsp_run = 0;
      end
      if (rsp_hold == 0 && rsp_run == 0) begin
         rsp_run = $urandom_range(1, 40);
         if (!fast_mode && !steady) rsp_hold = pick_gap();
      end
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_tready <= 1'b1;
         rsp_run--;
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(result_type'(rsp_tdata));
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Offers one request and waits until the block takes it.
   task automatic send(input logic [1:0] op, input logic [7:0] data_byte, input logic rs_select);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= {rs_select, op};
      req_tdata <= data_byte;
      do @(posedge clock); while (!req_tready);
      if (sb.note_request(op, data_byte, rs_select)) active_requests++;
   endtask

   task automatic sender_gap();
      int unsigned n;
      n = (steady || fast_mode) ? 0 : pick_gap();
      if (n > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // Ticks until the sequencer is predicted idle.
   task automatic tick_until_idle();
      while (sb.busy()) begin
         send(OP_TICK, 8'($urandom), 1'($urandom));
         sender_gap();
      end
   endtask

   // Stops sending and waits until every expected result has come back.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes all four timing registers, one per cycle.
   task automatic write_regs(input logic [15:0] pulse, input logic [15:0] gap,
                             input logic [15:0] settle, input logic [15:0] power_on);
      csr_reg_type regs [4];
      logic [15:0] vals [4];
      regs = '{REG_PULSE, REG_GAP, REG_SETTLE, REG_POWER_ON};
      vals = '{pulse, gap, settle, power_on};
      for (int i = 0; i < 4; i++) begin
         @(negedge clock);
         csr_we <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         sb.set_reg(regs[i], vals[i]);
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // One random request: mostly well-formed sequences, with refused requests as noise.
   task automatic random_request();
      int unsigned r;
      logic [1:0]  op;
      r = $urandom_range(0, 99);
      if (!sb.busy())
         op = (r < 45) ? OP_SUBMIT : (r < 60) ? OP_INIT : (r < 95) ? OP_TICK : OP_UNUSED;
      else
         op = (r < 82) ? OP_TICK : (r < 92) ? OP_SUBMIT : (r < 97) ? OP_INIT : OP_UNUSED;
      send(op, 8'($urandom), 1'($urandom));
      sender_gap();
   endtask

   // Back-to-back request with random content, used while the receiver holds off.
   task automatic random_request_no_gap();
      logic [1:0] op;
      op = sb.busy() ? OP_TICK : (($urandom_range(0, 1) == 0) ? OP_SUBMIT : OP_INIT);
      send(op, 8'($urandom), 1'($urandom));
   endtask

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed requests at the reset timing: idle tick, unused code, refused requests.
      send(OP_TICK, 8'h00, 1'b0);
      send(OP_UNUSED, 8'hFF, 1'b1);
      send(OP_SUBMIT, 8'hFF, 1'b1);
      send(OP_SUBMIT, 8'h00, 1'b0);
      send(OP_INIT, 8'h55, 1'b1);
      send(OP_UNUSED, 8'hAA, 1'b0);
      tick_until_idle();

      // Zero times: each submit and the whole init sequence finish within one request.
      drain();
      write_regs(16'd0, 16'd0, 16'd0, 16'd0);
      send(OP_SUBMIT, 8'h00, 1'b0);
      send(OP_SUBMIT, 8'hA5, 1'b1);
      send(OP_INIT, 8'hFF, 1'b1);
      send(OP_TICK, 8'h3C, 1'b0);

      // Init without a power-on wait and with no gap between nibbles.
      drain();
      write_regs(16'd1, 16'd0, 16'd2, 16'd0);
      send(OP_INIT, 8'h00, 1'b0);
      tick_until_idle();

      // Long pulse with the other times at their largest, then new values written
      // while the pulse is still counting.
      drain();
      fast_mode = 1'b1;
      write_regs(16'd240, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send(OP_SUBMIT, 8'h5A, 1'b1);
      repeat (200) send(OP_TICK, 8'($urandom), 1'($urandom));
      drain();
      write_regs(16'd2, 16'd0, 16'd1, 16'd3);
      tick_until_idle();
      drain();
      fast_mode = 1'b0;

      // Random phases, each with its own timing; the first keeps the reset values.
      active_requests = 0;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         drain();
         if (ph == 0)
            write_regs(PULSE_RESET, GAP_RESET, SETTLE_RESET, POWER_ON_RESET);
         else
            write_regs(pick_time(), pick_time(), pick_time(), pick_time());
         steady = (ph == 3);
         if (ph == 2) begin
            // The receiver holds off while requests keep coming, so the input stalls.
            long_hold_req = 1'b1;
            repeat (40) random_request_no_gap();
         end
         while (active_requests < (ph + 1) * ITEMS_PER_PHASE) random_request();
      end
      steady = 1'b0;

      drain();
      repeat (8) @(posedge clock);
      if (sb.failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> files.f
design/lcdseq_pkg.sv
design/lcdseq_csr.sv
design/lcdseq_engine.sv
design/char_lcd_nibble_write_sequencer.sv
tb/sv/char_lcd_nibble_write_sequencer_tb.sv
